// ===== hw/rtl/kffpa_pkg.sv =====
// Package of the keyed first-fit page allocator: page entry and fit result types,
// register indexes, sequencer states and the per-type byte cost table.
// Has no dependencies; every other file of the block imports it.
package kffpa_pkg;

	localparam int TYPE_W = 3;
	localparam int BLEND_W = 3;
	localparam int COUNT_W = 24;
	localparam int COST_W = 11;
	localparam int NEED_W = COUNT_W + COST_W;
	localparam int BYTES_W = 40;
	localparam int INDEX_OUT_W = 6;
	localparam int CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_CAPACITY = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_BLEND = 8'd1;
	localparam logic [BYTES_W-1:0] CAPACITY_RESET = 40'd4194304;

	localparam logic [TYPE_W-1:0] PRIM_HEX = 3'd0;
	localparam logic [TYPE_W-1:0] PRIM_TET = 3'd1;
	localparam logic [TYPE_W-1:0] PRIM_QUAD = 3'd2;
	localparam logic [TYPE_W-1:0] PRIM_TRI = 3'd3;
	localparam logic [TYPE_W-1:0] PRIM_LINE = 3'd4;
	localparam logic [TYPE_W-1:0] PRIM_POLYLINE = 3'd5;

	typedef struct packed {
		logic [TYPE_W-1:0] prim_type;
		logic [BLEND_W-1:0] blend_mode;
		logic [BYTES_W-1:0] used;
		logic [BYTES_W-1:0] limit;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic [BYTES_W-1:0] sum;
	} fit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCAN,
		ST_WRITE
	} state_t;

	function automatic logic [COST_W-1:0] cost_of(input logic [TYPE_W-1:0] prim);
		logic [COST_W-1:0] cost;
		unique case (prim)
			PRIM_HEX: cost = 11'd1008;
			PRIM_TET: cost = 11'd480;
			PRIM_QUAD: cost = 11'd168;
			PRIM_TRI: cost = 11'd120;
			PRIM_LINE: cost = 11'd168;
			PRIM_POLYLINE: cost = 11'd1512;
			default: cost = '0;
		endcase
		return cost;
	endfunction

endpackage

// ===== hw/rtl/kffpa_fit_unit.sv =====
// Shared fit unit: checks one stored page against the request key and byte need,
// and forms the saturated used count. Depends on kffpa_pkg.
module kffpa_fit_unit (
	input kffpa_pkg::entry_t entry,
	input logic [kffpa_pkg::TYPE_W-1:0] prim_type,
	input logic [kffpa_pkg::BLEND_W-1:0] blend_mode,
	input logic match_blend,
	input logic [kffpa_pkg::NEED_W-1:0] need,
	output kffpa_pkg::fit_t result
);
	import kffpa_pkg::*;

	logic [BYTES_W:0] sum_wide;
	logic key_ok;

	always_comb begin
		sum_wide = {1'b0, entry.used} + (BYTES_W + 1)'(need);
		key_ok = (entry.prim_type == prim_type)
			&& (!match_blend || (entry.blend_mode == blend_mode));
		result.hit = key_ok && (sum_wide <= {1'b0, entry.limit});
		result.sum = sum_wide[BYTES_W] ? {BYTES_W{1'b1}} : sum_wide[BYTES_W-1:0];
	end

endmodule

// ===== hw/rtl/kffpa_page_mem.sv =====
// Page table memory: one entry per page, one write and one registered read a cycle.
// Depends on kffpa_pkg for the entry type.
module kffpa_page_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output kffpa_pkg::entry_t rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input kffpa_pkg::entry_t wr_data
);
	import kffpa_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/keyed_first_fit_page_allocator.sv =====
// Keyed first-fit page allocator. The sequencer accepts a request, multiplies the element
// count by the type's byte cost, scans the stored pages in creation order through the
// shared fit unit behind the registered memory read, and then updates the page; the update
// waits while the result register is still full. A new request is taken the cycle after
// the result is loaded.
// Reset clears the page count and restores the register defaults; the page memory is
// not cleared, as only pages below the count are ever read.
module keyed_first_fit_page_allocator #(
	parameter int MAX_PAGES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata, // element_count
	input logic [5:0] s_tuser, // prim_type, blend_mode
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata, // page_index, used_after, zero padding
	output logic [1:0] m_tuser, // page_created, table_full
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [kffpa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [kffpa_pkg::BYTES_W-1:0] cfg_data
);
	import kffpa_pkg::*;

	localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PAGES);

	state_t state_q, state_d;

	logic [BYTES_W-1:0] capacity_q;
	logic match_blend_q;
	logic [CW-1:0] count_q;

	logic [TYPE_W-1:0] type_q;
	logic [BLEND_W-1:0] blend_q;
	logic [COUNT_W-1:0] elems_q;
	logic [NEED_W-1:0] need_q;

	logic [CW-1:0] idx_q;
	logic rvalid_q;
	logic [IW-1:0] ridx_q;
	logic [IW-1:0] widx_q;
	entry_t wr_q;
	logic created_q;
	logic full_q;

	logic m_tvalid_q;
	logic [INDEX_OUT_W-1:0] m_index_q;
	logic [BYTES_W-1:0] m_used_q;
	logic m_created_q;
	logic m_full_q;

	entry_t rd_data;
	fit_t fit;
	logic issue, hit, miss, out_free, fire, wr_en;

	kffpa_page_mem #(
		.DEPTH(MAX_PAGES),
		.AW(IW)
	) u_mem (
		.clk(clk),
		.rd_en(issue),
		.rd_addr(idx_q[IW-1:0]),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(widx_q),
		.wr_data(wr_q)
	);

	kffpa_fit_unit u_fit (
		.entry(rd_data),
		.prim_type(type_q),
		.blend_mode(blend_q),
		.match_blend(match_blend_q),
		.need(need_q),
		.result(fit)
	);

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		hit = (state_q == ST_SCAN) && rvalid_q && fit.hit;
		issue = (state_q == ST_SCAN) && !hit && (idx_q < count_q);
		miss = (state_q == ST_SCAN) && !hit && !rvalid_q && (idx_q >= count_q);
		out_free = !m_tvalid_q || m_tready;
		fire = (state_q == ST_WRITE) && out_free;
		wr_en = fire && !full_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_SCAN;
			ST_SCAN: begin
				if (hit || miss) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			capacity_q <= CAPACITY_RESET;
			match_blend_q <= 1'b0;
			count_q <= '0;
			rvalid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == CFG_PAGE_CAPACITY) begin
					capacity_q <= cfg_data;
				end else if (cfg_index == CFG_MATCH_BLEND) begin
					match_blend_q <= cfg_data[0];
				end
			end
			if (state_q == ST_MUL) begin
				rvalid_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				rvalid_q <= issue;
			end
			if (fire) begin
				if (created_q) begin
					count_q <= count_q + CW'(1);
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_q <= s_tuser[2:0];
			blend_q <= s_tuser[5:3];
			elems_q <= s_tdata;
		end
		if (state_q == ST_MUL) begin
			need_q <= NEED_W'(elems_q) * NEED_W'(cost_of(type_q));
			idx_q <= '0;
		end
		if (issue) begin
			ridx_q <= idx_q[IW-1:0];
			idx_q <= idx_q + CW'(1);
		end
		if (hit) begin
			widx_q <= ridx_q;
			wr_q.prim_type <= rd_data.prim_type;
			wr_q.blend_mode <= rd_data.blend_mode;
			wr_q.used <= fit.sum;
			wr_q.limit <= rd_data.limit;
			created_q <= 1'b0;
			full_q <= 1'b0;
		end else if (miss) begin
			widx_q <= count_q[IW-1:0];
			wr_q.prim_type <= type_q;
			wr_q.blend_mode <= blend_q;
			wr_q.used <= BYTES_W'(need_q);
			wr_q.limit <= capacity_q;
			created_q <= (count_q < MAX_COUNT);
			full_q <= (count_q >= MAX_COUNT);
		end
		if (fire) begin
			m_index_q <= full_q ? '0 : INDEX_OUT_W'(widx_q);
			m_used_q <= full_q ? '0 : wr_q.used;
			m_created_q <= created_q;
			m_full_q <= full_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {2'b00, m_used_q, m_index_q};
	assign m_tuser = {m_full_q, m_created_q};

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= MAX_COUNT)
		else $error("Page count exceeds the table depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= count_q))
		else $error("Scan index ran past the page count.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && created_q) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("Page count did not grow when a page was opened.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && full_q) |-> (count_q == MAX_COUNT && !created_q && !wr_en))
		else $error("Table full reported while a slot remained free.");

endmodule

// ===== test/keyed_first_fit_page_allocator_tb.sv =====
// Self-checking testbench for the keyed first-fit page allocator: drives requests through
// randomised handshakes and predicts every grant from a page table held in the bench.
// Depends on kffpa_pkg and the keyed_first_fit_page_allocator RTL only.
`timescale 1ns / 1ps

module keyed_first_fit_page_allocator_tb;
	import kffpa_pkg::*;

	localparam int PAGES = 64;
	localparam int VB_BYTES = 36;
	localparam int IB_BYTES = 4;
	localparam int SEGMENTS = 9;
	localparam int SETTLE_CYCLES = PAGES + 8;
	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	typedef struct packed {
		logic [TYPE_W-1:0] prim;
		logic [BLEND_W-1:0] blend;
		logic [COUNT_W-1:0] count;
		logic drain;
	} request_t;

	typedef struct packed {
		logic [INDEX_OUT_W-1:0] page;
		logic created;
		logic full;
		logic [BYTES_W-1:0] used;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [5:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [BYTES_W-1:0] cfg_data = '0;

	logic [BYTES_W-1:0] capacity_q = CAPACITY_RESET;
	logic blend_key_q = 1'b0;
	int unsigned page_total = 0;
	logic [TYPE_W-1:0] pg_type [PAGES];
	logic [BLEND_W-1:0] pg_blend [PAGES];
	logic [BYTES_W-1:0] pg_used [PAGES];
	logic [BYTES_W-1:0] pg_limit [PAGES];

	request_t pending_q[$];
	grant_t expected_q[$];
	request_t cur;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_results = 0;
	int unsigned n_fit = 0;
	int unsigned n_opened = 0;
	int unsigned n_full = 0;

	keyed_first_fit_page_allocator #(
		.MAX_PAGES(PAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [COST_W-1:0] byte_cost(input logic [TYPE_W-1:0] prim);
		case (prim)
			PRIM_HEX: return COST_W'(24 * VB_BYTES + 36 * IB_BYTES);
			PRIM_TET: return COST_W'(12 * VB_BYTES + 12 * IB_BYTES);
			PRIM_QUAD: return COST_W'(4 * VB_BYTES + 6 * IB_BYTES);
			PRIM_TRI: return COST_W'(3 * VB_BYTES + 3 * IB_BYTES);
			PRIM_LINE: return COST_W'(4 * VB_BYTES + 6 * IB_BYTES);
			PRIM_POLYLINE: return COST_W'(SEGMENTS * (4 * VB_BYTES + 6 * IB_BYTES));
			default: return '0;
		endcase
	endfunction

	// First fit in creation order, otherwise a new page, otherwise a refusal.
	task automatic place_request(input request_t rq, output grant_t g);
		logic [NEED_W-1:0] need;
		logic [BYTES_W:0] sum;
		bit done;
		need = rq.count * byte_cost(rq.prim);
		done = 1'b0;
		g = '0;
		for (int i = 0; i < page_total; i++) begin
			if (!done && pg_type[i] == rq.prim && (!blend_key_q || pg_blend[i] == rq.blend)) begin
				sum = {1'b0, pg_used[i]} + need;
				if (sum <= {1'b0, pg_limit[i]}) begin
					pg_used[i] = sum > BYTES_MAX ? BYTES_MAX : sum[BYTES_W-1:0];
					g.page = 6'(i);
					g.used = pg_used[i];
					done = 1'b1;
					n_fit++;
				end
			end
		end
		if (!done) begin
			if (page_total < PAGES) begin
				pg_type[page_total] = rq.prim;
				pg_blend[page_total] = rq.blend;
				pg_limit[page_total] = capacity_q;
				pg_used[page_total] = 40'(need);
				g.page = 6'(page_total);
				g.created = 1'b1;
				g.used = 40'(need);
				page_total++;
				n_opened++;
			end else begin
				g.full = 1'b1;
				n_full++;
			end
		end
	endtask

	always @(posedge clk) begin : driver
		grant_t g;
		logic busy;
		busy = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				place_request(cur, g);
				expected_q = {expected_q, g};
				n_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct
						&& (!pending_q[0].drain || expected_q.size() == 0)) begin
					cur = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur.count;
					s_tuser <= {cur.blend, cur.prim};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [BYTES_W-1:0] want,
			input logic [BYTES_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : monitor
		grant_t want;
		grant_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.page = m_tdata[5:0];
				got.used = m_tdata[45:6];
				got.created = m_tuser[0];
				got.full = m_tuser[1];
				n_results++;
				if (expected_q.size() == 0) begin
					$display("%0t ns: unexpected transaction, expected none, got page %0d used %0d",
						$time, got.page, got.used);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("page_index", 40'(want.page), 40'(got.page));
					check_field("page_created", 40'(want.created), 40'(got.created));
					check_field("table_full", 40'(want.full), 40'(got.full));
					check_field("used_after", want.used, got.used);
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic add_request(input logic [TYPE_W-1:0] prim, input logic [BLEND_W-1:0] blend,
			input logic [COUNT_W-1:0] count, input logic drain);
		request_t rq;
		rq.prim = prim;
		rq.blend = blend;
		rq.count = count;
		rq.drain = drain;
		pending_q = {pending_q, rq};
	endtask

	// Small counts dominate so that pages fill up gradually and many requests fit.
	function automatic request_t random_request();
		request_t rq;
		int pick;
		rq.prim = $urandom_range(99) < 90 ? 3'($urandom_range(5)) : 3'(6 + $urandom_range(1));
		rq.blend = $urandom_range(99) < 90 ? 3'($urandom_range(4)) : 3'(5 + $urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 40)
			rq.count = 24'($urandom_range(63));
		else if (pick < 70)
			rq.count = 24'($urandom_range(4095));
		else if (pick < 90)
			rq.count = 24'($urandom_range(65535));
		else
			rq.count = 24'($urandom);
		rq.drain = ($urandom_range(39) == 0);
		return rq;
	endfunction

	task automatic wait_drained();
		while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTES_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PAGE_CAPACITY)
			capacity_q = value;
		else if (idx == CFG_MATCH_BLEND)
			blend_key_q = value[0];
	endtask

	task automatic run_phase(input int items, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < items; i++)
			pending_q = {pending_q, random_request()};
		wait_drained();
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: fits, overflowing new pages, unknown types and toggled counts.
		add_request(PRIM_HEX, 3'd0, 24'd0, 1'b0);
		add_request(PRIM_HEX, 3'd1, 24'd4161, 1'b0);
		add_request(PRIM_HEX, 3'd2, 24'd1, 1'b0);
		add_request(PRIM_TET, 3'd3, 24'd100, 1'b0);
		add_request(PRIM_QUAD, 3'd4, 24'd1000, 1'b0);
		add_request(PRIM_TRI, 3'd5, 24'd7, 1'b0);
		add_request(PRIM_LINE, 3'd6, 24'd255, 1'b0);
		add_request(PRIM_POLYLINE, 3'd7, 24'hFFFFFF, 1'b0);
		add_request(PRIM_POLYLINE, 3'd0, 24'd1, 1'b1);
		add_request(3'd6, 3'd1, 24'hFFFFFF, 1'b0);
		add_request(3'd7, 3'd2, 24'd12345, 1'b0);
		add_request(3'd6, 3'd3, 24'd5, 1'b0);
		add_request(PRIM_QUAD, 3'd2, 24'hAAAAAA, 1'b0);
		add_request(PRIM_QUAD, 3'd5, 24'h555555, 1'b0);
		add_request(PRIM_TRI, 3'd0, 24'd1, 1'b0);
		add_request(PRIM_LINE, 3'd4, 24'd24966, 1'b0);
		wait_drained();

		// Zero capacity with blend keys: such a page only takes a zero need.
		write_reg(CFG_PAGE_CAPACITY, '0);
		write_reg(CFG_MATCH_BLEND, 40'd1);
		write_reg(8'd2, 40'({$urandom, $urandom}));
		write_reg(8'hFF, BYTES_MAX);
		add_request(PRIM_TET, 3'd6, 24'd0, 1'b0);
		add_request(PRIM_TET, 3'd6, 24'd0, 1'b0);
		add_request(PRIM_TET, 3'd6, 24'd1, 1'b0);
		run_phase(8, 0, 0);

		write_reg(CFG_PAGE_CAPACITY, BYTES_MAX);
		write_reg(CFG_MATCH_BLEND, 40'hFF_FFFF_FFFE);
		add_request(PRIM_HEX, 3'd3, 24'hFFFFFF, 1'b1);
		run_phase(120, 87, 0);

		// A one-byte budget with blend keys fills the table quickly.
		write_reg(CFG_PAGE_CAPACITY, 40'd1);
		write_reg(CFG_MATCH_BLEND, 40'd1);
		run_phase(120, 0, 87);

		write_reg(CFG_PAGE_CAPACITY, 40'({$urandom, $urandom}));
		write_reg(CFG_MATCH_BLEND, 40'd0);
		run_phase(120, 33, 33);

		write_reg(CFG_MATCH_BLEND, 40'd1);
		run_phase(120, 0, 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests over six register settings: %0d fitted, %0d opened a page,",
			n_sent, n_fit, n_opened);
		$display("%0d refused with a full table; %0d results compared, %0d mismatches.",
			n_full, n_results, errors);
		if (errors == 0 && expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d requests pending and %0d results outstanding.",
			pending_q.size(), expected_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
